>>> hw/rtl/sdt_pkg.sv
package sdt_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int OP_W     = 1;
  localparam int ADDR_W   = 48;
  localparam int BYTE_W   = 8;
  localparam int RIDX_W   = 5;
  localparam int OUTC_W   = 2;
  localparam int USED_W   = 6;
  localparam int ENTRY_W  = ADDR_W + 3 * BYTE_W;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_REPORT = 1'b0;
  localparam logic [OP_W-1:0] OP_READ   = 1'b1;

  // Result outcome codes
  typedef enum logic [OUTC_W-1:0] {
    OUT_UPDATED  = 2'd0,
    OUT_INSERTED = 2'd1,
    OUT_DROPPED  = 2'd2,
    OUT_READ     = 2'd3
  } outcome_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming request, restart the scan
    logic scan;     // step the address search
    logic finish;   // commit the table write and load the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic match;      // compared entry holds the request address
    logic exhausted;  // every filled entry compared without a hit
    logic out_free;   // result register can take a new result this cycle
  } dp_status_t;

endpackage

>>> hw/rtl/sdt_if.sv
// Request channel: one report or read request
interface sdt_req_if;
  logic              valid;
  logic              ready;
  logic [0:0]        op;
  logic [47:0]       dev_addr;
  logic signed [7:0] signal_level;
  logic [7:0]        dev_status;
  logic [7:0]        dev_count_byte;
  logic [4:0]        read_index;

  modport source (output valid, op, dev_addr, signal_level, dev_status, dev_count_byte,
                  read_index, input ready);
  modport sink   (input valid, op, dev_addr, signal_level, dev_status, dev_count_byte,
                  read_index, output ready);
endinterface

// Result channel: one result per request
interface sdt_rsp_if;
  logic              valid;
  logic              ready;
  logic [1:0]        outcome;
  logic [4:0]        entry_index;
  logic              entry_valid;
  logic [47:0]       entry_addr;
  logic signed [7:0] entry_level;
  logic [7:0]        entry_status;
  logic [7:0]        entry_counter;
  logic [5:0]        used_entries;

  modport source (output valid, outcome, entry_index, entry_valid, entry_addr, entry_level,
                  entry_status, entry_counter, used_entries, input ready);
  modport sink   (input valid, outcome, entry_index, entry_valid, entry_addr, entry_level,
                  entry_status, entry_counter, used_entries, output ready);
endinterface

>>> hw/rtl/scan_device_table.sv
// Deduplicating table of scanned devices, up to TABLE_DEPTH entries keyed by a
// 48-bit address. A report request searches the filled entries one per cycle
// through the table RAM's single read port, then updates the first matching
// entry, appends a new one, or drops the report when the table is full. A read
// request returns one entry by index. Every request gives exactly one result,
// held in an output register so the next request can be taken while it waits.
// A report that hits entry k ends its search there; a miss first compares
// every filled entry. A read waits for the registered RAM read. The request
// port is ready again the cycle after the result is loaded. The table needs
// no clearing after reset: the fill count alone marks valid entries.
module scan_device_table
  import sdt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sdt_req_if.sink   req,
  sdt_rsp_if.source rsp
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic [OUTC_W-1:0] outcome;

  sdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_op    (req.op),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sdt_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .in_op             (req.op),
    .in_dev_addr       (req.dev_addr),
    .in_signal_level   (req.signal_level),
    .in_dev_status     (req.dev_status),
    .in_dev_count_byte (req.dev_count_byte),
    .in_read_index     (req.read_index),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .outcome           (outcome),
    .entry_index       (rsp.entry_index),
    .entry_valid       (rsp.entry_valid),
    .entry_addr        (rsp.entry_addr),
    .entry_level       (rsp.entry_level),
    .entry_status      (rsp.entry_status),
    .entry_counter     (rsp.entry_counter),
    .used_entries      (rsp.used_entries)
  );

  assign rsp.outcome = outcome;

endmodule

>>> hw/rtl/sdt_ram.sv
// Simple dual-port RAM, registered read
module sdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/sdt_ctrl.sv
module sdt_ctrl
  import sdt_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  input  dp_status_t      status,
  output ctrl_cmd_t       cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = (in_op == OP_READ) ? ST_READ : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.match || status.exhausted) begin
          state_next = ST_FINISH;
        end
      end
      // wait for the registered RAM read
      ST_READ: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/sdt_dp.sv
module sdt_dp
  import sdt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_cmd_t                cmd,
  output dp_status_t               status,
  // request payload
  input  logic [OP_W-1:0]          in_op,
  input  logic [ADDR_W-1:0]        in_dev_addr,
  input  logic signed [BYTE_W-1:0] in_signal_level,
  input  logic [BYTE_W-1:0]        in_dev_status,
  input  logic [BYTE_W-1:0]        in_dev_count_byte,
  input  logic [RIDX_W-1:0]        in_read_index,
  // result register
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [OUTC_W-1:0]        outcome,
  output logic [RIDX_W-1:0]        entry_index,
  output logic                     entry_valid,
  output logic [ADDR_W-1:0]        entry_addr,
  output logic signed [BYTE_W-1:0] entry_level,
  output logic [BYTE_W-1:0]        entry_status,
  output logic [BYTE_W-1:0]        entry_counter,
  output logic [USED_W-1:0]        used_entries
);

  // Request held for the duration of the item
  logic [OP_W-1:0]          req_op;
  logic [ADDR_W-1:0]        req_addr;
  logic signed [BYTE_W-1:0] req_level;
  logic [BYTE_W-1:0]        req_status;
  logic [BYTE_W-1:0]        req_counter;
  logic [RIDX_W-1:0]        req_index;

  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   scan_idx;
  logic               cmp_valid;
  logic [IDX_W-1:0]   cmp_idx;
  logic               found;
  logic [IDX_W-1:0]   found_idx;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               match_now;
  logic               issue;
  logic               has_room;
  logic               read_hit;

  sdt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Search pipeline: issue one entry a cycle, compare it the cycle after
  assign match_now = cmp_valid && (ram_rdata[ENTRY_W-1 -: ADDR_W] == req_addr);
  assign issue     = (scan_idx < fill) && !match_now;
  assign has_room  = (32'(fill) < TABLE_DEPTH);
  assign read_hit  = (32'(req_index) < 32'(fill));

  assign ram_raddr = (req_op == OP_READ) ? IDX_W'(req_index) : IDX_W'(scan_idx);

  assign status.match     = cmd.scan && match_now;
  assign status.exhausted = cmd.scan && !cmp_valid && (scan_idx == fill);
  assign status.out_free  = !out_valid || out_ready;

  // Table write on commit: update in place on a hit, append otherwise
  assign ram_we    = cmd.finish && (req_op == OP_REPORT) && (found || has_room);
  assign ram_waddr = found ? found_idx : IDX_W'(fill);
  assign ram_wdata = {req_addr, req_level, req_status, req_counter};

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op      <= in_op;
      req_addr    <= in_dev_addr;
      req_level   <= in_signal_level;
      req_status  <= in_dev_status;
      req_counter <= in_dev_count_byte;
      req_index   <= in_read_index;
    end
  end

  // Search state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.capture) begin
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.scan) begin
      cmp_valid <= issue;
      if (issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (match_now) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      cmp_idx <= IDX_W'(scan_idx);
      if (match_now) begin
        found_idx <= cmp_idx;
      end
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ram_we && !found) begin
      fill <= fill + 1'b1;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      entry_addr    <= '0;
      entry_level   <= '0;
      entry_status  <= '0;
      entry_counter <= '0;
      entry_valid   <= 1'b0;
      entry_index   <= '0;
      used_entries  <= USED_W'(fill);
      if (req_op == OP_READ) begin
        outcome     <= OUT_READ;
        entry_index <= req_index;
        if (read_hit) begin
          entry_valid   <= 1'b1;
          entry_addr    <= ram_rdata[ENTRY_W-1 -: ADDR_W];
          entry_level   <= ram_rdata[3*BYTE_W-1 -: BYTE_W];
          entry_status  <= ram_rdata[2*BYTE_W-1 -: BYTE_W];
          entry_counter <= ram_rdata[BYTE_W-1:0];
        end
      end else if (found || has_room) begin
        outcome       <= found ? OUT_UPDATED : OUT_INSERTED;
        entry_index   <= found ? RIDX_W'(found_idx) : RIDX_W'(fill);
        entry_valid   <= 1'b1;
        entry_addr    <= req_addr;
        entry_level   <= req_level;
        entry_status  <= req_status;
        entry_counter <= req_counter;
        if (!found) begin
          used_entries <= USED_W'(fill + 1'b1);
        end
      end else begin
        outcome <= OUT_DROPPED;
      end
    end
  end

endmodule
